// ----- design/assert_macros.svh -----
// Assertion macros shared by the soft-clip score spreader modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, switched off while rst is high.
`define SCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every rising edge of clk, reset cycles included.
`define SCS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/scs_pkg.sv -----
// Package with the types, constants and register codes of the soft-clip score spreader.
package scs_pkg;

  localparam int DEFAULT_MAX_DEPTH  = 64;
  localparam int DEFAULT_SCORE_BITS = 16;

  localparam int CLIP_W      = 8;
  localparam int MP_W        = 7;
  localparam int THR_W       = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 2;

  localparam int ACC_W   = 24;
  localparam int ONE_W   = 13;
  localparam int DEN_W   = 25;
  localparam int QUOT_W  = 16;
  localparam int DIV_STEPS = QUOT_W + 1;

  localparam logic [ACC_W-1:0] ACC_MAX = 24'hFF_FFFF;
  localparam logic [ONE_W-1:0] ONE_Q12 = 13'd4096;

  localparam logic [MP_W-1:0]  MP_RESET     = 7'd8;
  localparam logic [THR_W-1:0] THR_RESET    = 8'd2;
  localparam logic             SQUASH_RESET = 1'b0;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PROP = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_CLIP = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SQUASH   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPREAD,
    ST_SETTLE,
    ST_FETCH,
    ST_UPDATE,
    ST_DIVIDE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic clear_en;
    logic load_in;
    logic spread_step;
    logic fetch;
    logic update;
    logic div_start;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cfg_clear;
    logic clear_last;
    logic hit;
    logic spread_last;
    logic squash;
    logic den_zero;
  } dp_status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- design/scs_div.sv -----
// Restoring divider that forms the squashed ratio one quotient bit per cycle.
`include "assert_macros.svh"

module scs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [scs_pkg::ACC_W-1:0]     dividend,
  input  logic [scs_pkg::DEN_W-1:0]     divisor,
  output scs_pkg::div_status_t          status,
  output logic [scs_pkg::QUOT_W-1:0]    quotient
);
  import scs_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam int REM_W = DEN_W + 1;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem;
  logic [DEN_W-1:0] div_q;
  logic [QUOT_W:0]  q;

  logic [REM_W-1:0] trial;
  logic             ge;

  // The first step compares the dividend itself; every later one doubles the remainder.
  always_comb begin
    trial = (cnt == '0) ? rem : {rem[REM_W-2:0], 1'b0};
    ge    = (trial >= REM_W'(div_q));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= REM_W'(dividend);
      div_q <= divisor;
      q     <= '0;
    end else if (busy) begin
      rem <= ge ? (trial - REM_W'(div_q)) : trial;
      q   <= {q[QUOT_W-1:0], ge};
    end
  end

  // A ratio of exactly one sets the top quotient bit and saturates.
  assign quotient    = q[QUOT_W] ? {QUOT_W{1'b1}} : q[QUOT_W-1:0];
  assign status.busy = busy;
  assign status.done = done;

  `SCS_ASSERT(a_start_idle, start |-> !busy, "divider started while busy")
  `SCS_ASSERT(a_done_on_fall, $fell(busy) |-> done, "divider finished without done")
  `SCS_ASSERT(a_rem_below, (busy && cnt != '0) |-> (rem < REM_W'(div_q)), "remainder not reduced")

endmodule

// ----- design/scs_datapath.sv -----
// Datapath of the soft-clip score spreader: registers, delay line memories and result register.
module scs_datapath #(
  parameter int MAX_DEPTH  = scs_pkg::DEFAULT_MAX_DEPTH,
  parameter int SCORE_BITS = scs_pkg::DEFAULT_SCORE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [scs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [scs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [SCORE_BITS-1:0]             score,
  input  logic [scs_pkg::CLIP_W-1:0]        clip_count,
  input  scs_pkg::ctrl_cmd_t                cmd,
  output scs_pkg::dp_status_t               status,
  output logic [scs_pkg::ACC_W-1:0]         div_dividend,
  output logic [scs_pkg::DEN_W-1:0]         div_divisor,
  input  logic [scs_pkg::QUOT_W-1:0]        div_quotient,
  output logic [scs_pkg::ACC_W-1:0]         value,
  output logic                              zero_denominator
);
  import scs_pkg::*;

  localparam int AW     = $clog2(MAX_DEPTH);
  localparam int PAW    = $clog2(MAX_DEPTH + 1);
  localparam int LEN_W  = $clog2(MAX_DEPTH + 1);
  localparam int LCMP_W = (LEN_W > MP_W) ? LEN_W : MP_W;
  localparam int RCMP_W = (LEN_W > CLIP_W) ? LEN_W : CLIP_W;
  localparam int SUM_W  = ((SCORE_BITS > ACC_W) ? SCORE_BITS : ACC_W) + 1;
  localparam int OCMP_W = (SCORE_BITS > ONE_W) ? SCORE_BITS : ONE_W;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [SCORE_BITS-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    return (s > SUM_W'(ACC_MAX)) ? ACC_MAX : s[ACC_W-1:0];
  endfunction

  // Configuration registers.
  logic [MP_W-1:0]  delay_len;
  logic [THR_W-1:0] min_clip;
  logic             squash;
  logic             cfg_clear;

  assign cfg_clear = cfg_write && (cfg_index == REG_MAX_PROP);

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_len <= MP_RESET;
      min_clip  <= THR_RESET;
      squash    <= SQUASH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAX_PROP: delay_len <= cfg_data[MP_W-1:0];
        REG_MIN_CLIP: min_clip  <= cfg_data[THR_W-1:0];
        REG_SQUASH:   squash    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Active line length: zero acts as one, and the length is capped at the memory depth.
  logic [MP_W-1:0]  mp_eff;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] radius_in;

  always_comb begin
    mp_eff    = (delay_len == '0) ? MP_W'(1) : delay_len;
    len       = (LCMP_W'(mp_eff) > LCMP_W'(MAX_DEPTH)) ? LEN_W'(MAX_DEPTH) : LEN_W'(mp_eff);
    radius_in = (RCMP_W'(clip_count) < RCMP_W'(len)) ? LEN_W'(clip_count) : len;
  end

  // Pointers, clearing sweep and spreading sweep.
  logic [PAW-1:0]   clr_cnt;
  logic             clr_in_line;
  logic [AW-1:0]    ptr;
  logic [PAW-1:0]   head;
  logic [SCORE_BITS-1:0] score_q;
  logic [LEN_W-1:0] radius_q;
  logic [LEN_W-1:0] step;
  logic [AW-1:0]    acc_run;
  logic [PAW-1:0]   pf_run;
  logic             wr_go;
  logic             wr_acc_en;
  logic [AW-1:0]    wr_acc_addr;
  logic [PAW-1:0]   wr_pf_addr;

  assign clr_in_line = (clr_cnt < PAW'(MAX_DEPTH));

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      clr_cnt <= '0;
      ptr     <= '0;
      head    <= '0;
    end else begin
      if (cmd.clear_en) begin
        clr_cnt <= clr_cnt + PAW'(1);
      end
      if (cmd.update) begin
        ptr  <= ((LEN_W'(ptr) + LEN_W'(1)) == len) ? '0 : ptr + AW'(1);
        head <= (head == PAW'(MAX_DEPTH)) ? '0 : head + PAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= '0;
      wr_go <= 1'b0;
    end else begin
      wr_go <= cmd.spread_step;
      if (cmd.load_in) begin
        step <= '0;
      end else if (cmd.spread_step) begin
        step <= step + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      score_q  <= score;
      radius_q <= radius_in;
      acc_run  <= ptr;
      pf_run   <= head;
    end else if (cmd.spread_step) begin
      acc_run <= (acc_run == '0) ? AW'(len - LEN_W'(1)) : acc_run - AW'(1);
      pf_run  <= (pf_run == PAW'(MAX_DEPTH)) ? '0 : pf_run + PAW'(1);
    end
    if (cmd.spread_step) begin
      wr_acc_en   <= (step != '0);
      wr_acc_addr <= acc_run;
      wr_pf_addr  <= pf_run;
    end
  end

  // Memories and their ports.
  logic [ACC_W-1:0]      accum_mem [0:MAX_DEPTH-1];
  logic [SCORE_BITS-1:0] raw_mem   [0:MAX_DEPTH-1];
  logic [ACC_W-1:0]      pf_mem    [0:MAX_DEPTH];

  logic [ACC_W-1:0]      acc_rd;
  logic [SCORE_BITS-1:0] raw_rd;
  logic [ACC_W-1:0]      pf_rd;
  logic [AW-1:0]         acc_ra;
  logic [PAW-1:0]        pf_ra;
  logic                  acc_we, raw_we, pf_we;
  logic [AW-1:0]         acc_wa, raw_wa;
  logic [PAW-1:0]        pf_wa;
  logic [ACC_W-1:0]      acc_wd, pf_wd, own;
  logic [SCORE_BITS-1:0] raw_wd;

  assign own    = sat_add(pf_rd, score_q);
  assign acc_ra = cmd.fetch ? ptr : acc_run;
  assign pf_ra  = cmd.fetch ? head : pf_run;

  always_comb begin
    acc_we = 1'b0;
    acc_wa = ptr;
    acc_wd = own;
    pf_we  = 1'b0;
    pf_wa  = head;
    pf_wd  = '0;
    raw_we = 1'b0;
    raw_wa = ptr;
    raw_wd = score_q;
    if (cmd.clear_en) begin
      acc_we = clr_in_line;
      acc_wa = AW'(clr_cnt);
      acc_wd = '0;
      pf_we  = 1'b1;
      pf_wa  = clr_cnt;
      raw_we = clr_in_line;
      raw_wa = AW'(clr_cnt);
      raw_wd = '0;
    end else if (wr_go) begin
      acc_we = wr_acc_en;
      acc_wa = wr_acc_addr;
      acc_wd = sat_add(acc_rd, score_q);
      pf_we  = 1'b1;
      pf_wa  = wr_pf_addr;
      pf_wd  = sat_add(pf_rd, score_q);
    end else if (cmd.update) begin
      acc_we = 1'b1;
      pf_we  = 1'b1;
      raw_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      accum_mem[acc_wa] <= acc_wd;
    end
    acc_rd <= accum_mem[acc_ra];
  end

  always_ff @(posedge clk) begin
    if (raw_we) begin
      raw_mem[raw_wa] <= raw_wd;
    end
    raw_rd <= raw_mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (pf_we) begin
      pf_mem[pf_wa] <= pf_wd;
    end
    pf_rd <= pf_mem[pf_ra];
  end

  // Squash denominator from the leaving value and its delayed raw score.
  logic             orig_big;
  logic [ONE_W-1:0] capped;
  logic [DEN_W-1:0] den;
  logic             den_zero;

  always_comb begin
    orig_big = (OCMP_W'(raw_rd) >= OCMP_W'(ONE_Q12));
    capped   = orig_big ? ONE_Q12 : ONE_W'(raw_rd);
    den      = DEN_W'(acc_rd) + DEN_W'(ONE_Q12) - DEN_W'(capped);
    den_zero = (den == '0);
  end

  assign div_dividend = acc_rd;
  assign div_divisor  = den;

  logic [ACC_W-1:0] leaving_q;
  logic             den_zero_q;

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      leaving_q  <= acc_rd;
      den_zero_q <= den_zero;
    end
    if (cmd.load_out) begin
      if (squash) begin
        value <= den_zero_q ? '0 : ACC_W'(div_quotient);
      end else begin
        value <= leaving_q;
      end
      zero_denominator <= squash && den_zero_q;
    end
  end

  assign status.cfg_clear   = cfg_clear;
  assign status.clear_last  = (clr_cnt == PAW'(MAX_DEPTH));
  assign status.hit         = (clip_count >= min_clip);
  assign status.spread_last = (step == radius_q);
  assign status.squash      = squash;
  assign status.den_zero    = den_zero;

endmodule

// ----- design/scs_ctrl.sv -----
// Controller state machine of the soft-clip score spreader.
`include "assert_macros.svh"

module scs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  scs_pkg::dp_status_t   st,
  input  scs_pkg::div_status_t  div,
  output scs_pkg::ctrl_cmd_t    cmd
);
  import scs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    if (st.cfg_clear) begin
      state_next = ST_CLEAR;
    end else begin
      unique case (state)
        ST_CLEAR:  if (st.clear_last) state_next = ST_IDLE;
        ST_IDLE:   if (in_valid) state_next = st.hit ? ST_SPREAD : ST_FETCH;
        ST_SPREAD: if (st.spread_last) state_next = ST_SETTLE;
        ST_SETTLE: state_next = ST_FETCH;
        ST_FETCH:  state_next = ST_UPDATE;
        ST_UPDATE: state_next = (st.squash && !st.den_zero) ? ST_DIVIDE : ST_RESULT;
        ST_DIVIDE: if (div.done) state_next = ST_RESULT;
        ST_RESULT: if (!out_valid || out_ready) state_next = ST_IDLE;
        default:   state_next = ST_CLEAR;
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR:  cmd.clear_en = 1'b1;
      ST_IDLE: begin
        in_ready    = !st.cfg_clear;
        cmd.load_in = in_valid && !st.cfg_clear;
      end
      ST_SPREAD: cmd.spread_step = 1'b1;
      ST_SETTLE: ;
      ST_FETCH:  cmd.fetch = 1'b1;
      ST_UPDATE: begin
        cmd.update    = 1'b1;
        cmd.div_start = st.squash && !st.den_zero;
      end
      ST_DIVIDE: ;
      ST_RESULT: cmd.load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `SCS_ASSERT_RST(a_reset_state, rst |=> (state == ST_CLEAR && !out_valid), "reset not applied")
  `SCS_ASSERT(a_accept_starts, (in_valid && in_ready) |=> (state == ST_SPREAD || state == ST_FETCH), "accepted item not started")
  `SCS_ASSERT(a_no_overwrite, cmd.load_out |-> (!out_valid || out_ready), "waiting result overwritten")
  `SCS_ASSERT(a_divide_running, (state == ST_DIVIDE) |-> (div.busy || div.done), "waiting on idle divider")

endmodule

// ----- design/soft_clip_score_spreader.sv -----
// Top level of the soft-clip score spreader: controller, datapath and squash divider.
//
// Channel   Dir  Handshake              Payload
// input     in   in_valid / in_ready    score, clip_count
// output    out  out_valid / out_ready  value, zero_denominator
// config    in   cfg_write (no wait)    cfg_index, cfg_data
//
// One item at a time. After its transfer an item passes the fetch, update and result
// states before the next possible transfer. When its clip count triggers spreading, it
// first spreads up to its radius (one read-modify-write of the forward queue per cycle,
// and of the delay line on all steps but the first) and passes a settle state. In squash
// mode, a nonzero denominator adds the bit-serial divider (17 quotient bits, one per cycle).
// Reset, and every write of max_propagation, start a clearing pass over the three
// memories; in_ready stays low until it is done.
// A finished result waits in the output register; a new item is taken meanwhile,
// and only its own result waits for the register to be free.
module soft_clip_score_spreader #(
  parameter int MAX_DEPTH  = scs_pkg::DEFAULT_MAX_DEPTH,
  parameter int SCORE_BITS = scs_pkg::DEFAULT_SCORE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [scs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [scs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [SCORE_BITS-1:0]             score,
  input  logic [scs_pkg::CLIP_W-1:0]        clip_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [scs_pkg::ACC_W-1:0]         value,
  output logic                              zero_denominator
);
  import scs_pkg::*;

  ctrl_cmd_t           cmd;
  dp_status_t          dp_status;
  div_status_t         div_status;
  logic [ACC_W-1:0]    div_dividend;
  logic [DEN_W-1:0]    div_divisor;
  logic [QUOT_W-1:0]   div_quotient;

  // The controller sequences clearing, spreading, the line update and the division.
  scs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (dp_status),
    .div       (div_status),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, the delay lines, the forward queue and
  // the output register.
  scs_datapath #(
    .MAX_DEPTH  (MAX_DEPTH),
    .SCORE_BITS (SCORE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .score            (score),
    .clip_count       (clip_count),
    .cmd              (cmd),
    .status           (dp_status),
    .div_dividend     (div_dividend),
    .div_divisor      (div_divisor),
    .div_quotient     (div_quotient),
    .value            (value),
    .zero_denominator (zero_denominator)
  );

  // The divider forms the squashed ratio of the value leaving the line.
  scs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_status),
    .quotient (div_quotient)
  );

endmodule
